// ===== src/bur_pkg.sv =====
// Shared types, register codes and constants for the bilinear upscale/rotate block.
// Used by bur_map and by the top level; depends on nothing else.
package bur_pkg;

  localparam int CHAN_BITS = 8;
  localparam int NUM_CHAN = 4;
  localparam logic [7:0] CHAN_MASK = 8'hff;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [10:0] SRC_WIDTH_RST = 11'd640;
  localparam logic [9:0] SRC_HEIGHT_RST = 10'd480;
  localparam logic [10:0] DST_WIDTH_RST = 11'd752;
  localparam logic [10:0] DST_HEIGHT_RST = 11'd560;
  localparam logic ROTATE_RST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_ROTATE     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Everything an item carries alongside the coordinate math.
  typedef struct packed {
    op_e         op;
    logic [9:0]  wr_col;
    logic [8:0]  wr_row;
    logic [31:0] wr_data;
    logic [9:0]  out_col;
    logic [9:0]  out_row;
  } side_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [31:0] pixel;
  } res_t;

  // Cycles from the mapper's inputs to its registered index and fraction.
  function automatic int map_latency(input int size_w, input int frac_w);
    return (size_w + ((size_w + frac_w) % 2) + frac_w) / 2 + 1;
  endfunction

endpackage

// ===== src/bilinear_upscale_rotate.sv =====
// Top level of the bilinear upscale/rotate block: frame banks, tap pipeline, output skid.
// Depends on bur_pkg and bur_map.

// Takes one beat per clock while in_stall_o is low, either a source-pixel write
// or a destination-pixel request. A request's result is formed by the coordinate
// divider, which resolves two quotient bits per stage, followed by the frame read
// and two multiply stages. The source frame lives in four banks split by column
// and row parity, so the four taps of a request are read in the same cycle.
// Writes pass through the same pipeline and reach the frame in order with
// requests. Pixels never written read as undefined. A two-entry output buffer
// keeps the input side open while one result waits on a stalled output.
module bilinear_upscale_rotate
  import bur_pkg::*;
#(
  parameter int MAX_SRC_W = 1024,
  parameter int MAX_SRC_H = 512,
  parameter int MAX_DST_W = 1024,
  parameter int MAX_DST_H = 1024,
  parameter int FRAC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  logic [9:0]            src_col_i,
  input  logic [8:0]            src_row_i,
  input  logic [31:0]           pixel_in_i,
  input  logic [9:0]            dst_col_i,
  input  logic [9:0]            dst_row_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [9:0]            out_col_o,
  output logic [9:0]            out_row_o,
  output logic [31:0]           pixel_out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SWW = $clog2(MAX_SRC_W + 1);
  localparam int SHW = $clog2(MAX_SRC_H + 1);
  localparam int SZW = (SWW > SHW) ? SWW : SHW;
  localparam int DWW = $clog2(MAX_DST_W + 1);
  localparam int DHW = $clog2(MAX_DST_H + 1);
  localparam int XW = $clog2(MAX_SRC_W);
  localparam int YW = $clog2(MAX_SRC_H);
  localparam int PW = 10 + SZW;
  localparam int FW = FRAC_BITS + 2;
  localparam int LAT = map_latency(SZW, FRAC_BITS);
  localparam int HALF_W = (MAX_SRC_W + 1) / 2;
  localparam int HALF_H = (MAX_SRC_H + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [10:0] src_width_q;
  logic [9:0]  src_height_q;
  logic [10:0] dst_width_q;
  logic [10:0] dst_height_q;
  logic        rotate_q;

  logic           en;
  logic [SZW-1:0] sw_c, sh_c;
  logic [DWW-1:0] dw_c;
  logic [DHW-1:0] dh_c;
  logic           req_ok, wr_ok, accept;
  side_t          side_in;

  side_t          sd_q [LAT+1];
  logic [PW-1:0]  prod_x_q, prod_y_q;
  logic [DWW-1:0] dw_q;
  logic [DHW-1:0] dh_q;
  logic [SZW-1:0] sw_q, sh_q;

  logic [XW-1:0]  xi;
  logic [YW-1:0]  yi;
  logic [FW-1:0]  fx, fy;

  logic [31:0]    bank_rd [4];
  side_t          m_side_q;
  logic           m_xlsb_q, m_ylsb_q;
  logic [FW-1:0]  m_fx_q, m_fy_q;

  logic [31:0]    p00, p01, p10, p11, ifx, fx32;
  logic [31:0]    top_d [NUM_CHAN];
  logic [31:0]    bot_d [NUM_CHAN];
  logic [31:0]    p1_top_q [NUM_CHAN];
  logic [31:0]    p1_bot_q [NUM_CHAN];
  side_t          p1_side_q;
  logic [FW-1:0]  p1_fy_q;
  logic [31:0]    ify, fy32;
  logic [31:0]    p2_t_q [NUM_CHAN];
  logic [31:0]    p2_b_q [NUM_CHAN];
  side_t          p2_side_q;

  res_t           res_new, out_q, skid_q;
  logic           out_v_q, skid_v_q, arrive;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q <= SRC_WIDTH_RST;
      src_height_q <= SRC_HEIGHT_RST;
      dst_width_q <= DST_WIDTH_RST;
      dst_height_q <= DST_HEIGHT_RST;
      rotate_q <= ROTATE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SRC_WIDTH: src_width_q <= cfg_data_i;
        CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[9:0];
        CFG_DST_WIDTH: dst_width_q <= cfg_data_i;
        CFG_DST_HEIGHT: dst_height_q <= cfg_data_i;
        CFG_ROTATE: rotate_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Entry stage: sizes, range checks, output position (mirrored when rotating), products.
  assign en = !skid_v_q;
  assign in_stall_o = skid_v_q;
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    sw_c = (32'(src_width_q) > 32'(MAX_SRC_W)) ? SZW'(MAX_SRC_W) : SZW'(src_width_q);
    sh_c = (32'(src_height_q) > 32'(MAX_SRC_H)) ? SZW'(MAX_SRC_H) : SZW'(src_height_q);
    dw_c = (32'(dst_width_q) > 32'(MAX_DST_W)) ? DWW'(MAX_DST_W) : DWW'(dst_width_q);
    dh_c = (32'(dst_height_q) > 32'(MAX_DST_H)) ? DHW'(MAX_DST_H) : DHW'(dst_height_q);
    req_ok = (32'(sw_c) >= 32'd2) && (32'(sh_c) >= 32'd2) &&
             (32'(dst_col_i) < 32'(dw_c)) && (32'(dst_row_i) < 32'(dh_c));
    wr_ok = (32'(src_col_i) < 32'(MAX_SRC_W)) && (32'(src_row_i) < 32'(MAX_SRC_H));
    side_in.op = OP_IDLE;
    if (accept) begin
      if (kind_i) begin
        side_in.op = req_ok ? OP_READ : OP_IDLE;
      end else begin
        side_in.op = wr_ok ? OP_WRITE : OP_IDLE;
      end
    end
    side_in.wr_col = src_col_i;
    side_in.wr_row = src_row_i;
    side_in.wr_data = pixel_in_i;
    side_in.out_col = rotate_q ? 10'(32'(dw_c) - 32'd1 - 32'(dst_col_i)) : dst_col_i;
    side_in.out_row = rotate_q ? 10'(32'(dh_c) - 32'd1 - 32'(dst_row_i)) : dst_row_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LAT; k++) begin
        sd_q[k] <= '0;
      end
    end else if (en) begin
      sd_q[0] <= side_in;
      for (int k = 1; k <= LAT; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_x_q <= PW'(dst_col_i) * PW'(sw_c);
      prod_y_q <= PW'(dst_row_i) * PW'(sh_c);
      dw_q <= dw_c;
      dh_q <= dh_c;
      sw_q <= sw_c;
      sh_q <= sh_c;
    end
  end

  bur_map #(
    .PW(PW), .DW(DWW), .SW(SZW), .IW(XW), .FRAC_BITS(FRAC_BITS)
  ) u_map_x (
    .clk_i(clk_i), .en_i(en), .prod_i(prod_x_q), .div_i(dw_q), .size_i(sw_q),
    .idx_o(xi), .frac_o(fx)
  );

  bur_map #(
    .PW(PW), .DW(DHW), .SW(SZW), .IW(YW), .FRAC_BITS(FRAC_BITS)
  ) u_map_y (
    .clk_i(clk_i), .en_i(en), .prod_i(prod_y_q), .div_i(dh_q), .size_i(sh_q),
    .idx_o(yi), .frac_o(fy)
  );

  // Frame banks, indexed {row parity, column parity}. Each bank is read every
  // enabled cycle and also written when the item at this stage is a write to it.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = 1'(b % 2);
    localparam logic RP = 1'(b / 2);

    logic [31:0]   mem [BANK_DEPTH];
    logic [31:0]   rd_q;
    logic [XW:0]   ccol;
    logic [YW:0]   crow;
    logic [AW-1:0] raddr, waddr;
    logic          wsel;

    always_comb begin
      ccol = (XW+1)'(xi) + (XW+1)'(CP ^ xi[0]);
      crow = (YW+1)'(yi) + (YW+1)'(RP ^ yi[0]);
      raddr = AW'(32'(crow >> 1) * 32'(HALF_W) + 32'(ccol >> 1));
      waddr = AW'(32'(sd_q[LAT].wr_row >> 1) * 32'(HALF_W) + 32'(sd_q[LAT].wr_col >> 1));
      wsel = (sd_q[LAT].op == OP_WRITE) && (sd_q[LAT].wr_col[0] == CP) &&
             (sd_q[LAT].wr_row[0] == RP);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (wsel) begin
          mem[waddr] <= sd_q[LAT].wr_data;
        end
        rd_q <= mem[raddr];
      end
    end

    assign bank_rd[b] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_side_q <= '0;
      p1_side_q <= '0;
      p2_side_q <= '0;
    end else if (en) begin
      m_side_q <= sd_q[LAT];
      p1_side_q <= m_side_q;
      p2_side_q <= p1_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_xlsb_q <= xi[0];
      m_ylsb_q <= yi[0];
      m_fx_q <= fx;
      m_fy_q <= fy;
    end
  end

  // Horizontal blend; the weights wrap in 32 bits when the fraction exceeds one.
  always_comb begin
    p00 = bank_rd[{m_ylsb_q, m_xlsb_q}];
    p01 = bank_rd[{m_ylsb_q, ~m_xlsb_q}];
    p10 = bank_rd[{~m_ylsb_q, m_xlsb_q}];
    p11 = bank_rd[{~m_ylsb_q, ~m_xlsb_q}];
    fx32 = 32'(m_fx_q);
    ifx = (32'd1 << FRAC_BITS) - fx32;
    for (int c = 0; c < NUM_CHAN; c++) begin
      top_d[c] = 32'(p00[c*CHAN_BITS +: CHAN_BITS]) * ifx +
                 32'(p01[c*CHAN_BITS +: CHAN_BITS]) * fx32;
      bot_d[c] = 32'(p10[c*CHAN_BITS +: CHAN_BITS]) * ifx +
                 32'(p11[c*CHAN_BITS +: CHAN_BITS]) * fx32;
    end
  end

  assign fy32 = 32'(p1_fy_q);
  assign ify = (32'd1 << FRAC_BITS) - fy32;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        p1_top_q[c] <= top_d[c];
        p1_bot_q[c] <= bot_d[c];
        p2_t_q[c] <= p1_top_q[c] * ify;
        p2_b_q[c] <= p1_bot_q[c] * fy32;
      end
      p1_fy_q <= m_fy_q;
    end
  end

  always_comb begin
    logic [31:0] sum;
    res_new.col = p2_side_q.out_col;
    res_new.row = p2_side_q.out_row;
    res_new.pixel = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum = p2_t_q[c] + p2_b_q[c];
      res_new.pixel[c*CHAN_BITS +: CHAN_BITS] = sum[2*FRAC_BITS +: CHAN_BITS] & CHAN_MASK;
    end
  end

  // Output register plus one skid entry; the pipeline halts only while the
  // skid entry is occupied.
  assign arrive = en && (p2_side_q.op == OP_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_q <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= arrive;
      end
    end else if (arrive) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (arrive) begin
        out_q <= res_new;
      end
    end else if (arrive) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_col_o = out_q.col;
  assign out_row_o = out_q.row;
  assign pixel_out_o = out_q.pixel;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid entry filled without a stalled output");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_stall_i) |=> (out_v_q && !skid_v_q))
    else $error("skid entry did not move to the output register");
`endif

endmodule

// ===== src/bur_map.sv =====
// Coordinate mapper: pipelined long division of coord*size*2^F by the destination
// size, two quotient bits per stage, then clamp of the index. Uses bur_pkg.
module bur_map
  import bur_pkg::*;
#(
  parameter int PW = 21,
  parameter int DW = 11,
  parameter int SW = 11,
  parameter int IW = 10,
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [PW-1:0]        prod_i,
  input  logic [DW-1:0]        div_i,
  input  logic [SW-1:0]        size_i,
  output logic [IW-1:0]        idx_o,
  output logic [FRAC_BITS+1:0] frac_o
);

  // The quotient is below size*2^F, so SH integer bits suffice; SH is padded
  // to keep the bit count even for two bits per stage.
  localparam int SH = SW + ((SW + FRAC_BITS) % 2);
  localparam int K = SH + FRAC_BITS;
  localparam int NS = map_latency(SW, FRAC_BITS) - 1;
  localparam int FW = FRAC_BITS + 2;

  logic [DW-1:0] rem_in [NS];
  logic [K-1:0]  quo_in [NS];
  logic [K-1:0]  bits_in [NS];
  logic [DW-1:0] div_in [NS];
  logic [DW-1:0] rem_d [NS];
  logic [K-1:0]  quo_d [NS];
  logic [K-1:0]  bits_d [NS];
  logic [DW-1:0] rem_q [NS];
  logic [K-1:0]  quo_q [NS];
  logic [K-1:0]  bits_q [NS];
  logic [DW-1:0] div_q [NS];
  logic [SW-1:0] size_q [NS];
  logic [IW-1:0] idx_d, idx_q;
  logic [FW-1:0] frac_d, frac_q;

  always_comb begin
    rem_in[0] = DW'(prod_i >> SH);
    quo_in[0] = '0;
    bits_in[0] = {prod_i[SH-1:0], {FRAC_BITS{1'b0}}};
    div_in[0] = div_i;
    for (int k = 1; k < NS; k++) begin
      rem_in[k] = rem_q[k-1];
      quo_in[k] = quo_q[k-1];
      bits_in[k] = bits_q[k-1];
      div_in[k] = div_q[k-1];
    end
  end

  always_comb begin
    logic [DW-1:0] r;
    logic [K-1:0]  q;
    logic [K-1:0]  b;
    logic [DW:0]   t;
    for (int k = 0; k < NS; k++) begin
      r = rem_in[k];
      q = quo_in[k];
      b = bits_in[k];
      for (int j = 0; j < 2; j++) begin
        t = {r, b[K-1]};
        if (t >= {1'b0, div_in[k]}) begin
          t = t - {1'b0, div_in[k]};
          q = {q[K-2:0], 1'b1};
        end else begin
          q = {q[K-2:0], 1'b0};
        end
        r = t[DW-1:0];
        b = {b[K-2:0], 1'b0};
      end
      rem_d[k] = r;
      quo_d[k] = q;
      bits_d[k] = b;
    end
  end

  // At the last column or row the index is pulled back to size-2 and the
  // fraction grows past one.
  always_comb begin
    logic [SH-1:0] ipart;
    logic [SW-1:0] lim;
    logic [SH-1:0] isel;
    ipart = quo_q[NS-1][K-1:FRAC_BITS];
    lim = size_q[NS-1] - SW'(2);
    isel = (32'(ipart) > 32'(lim)) ? SH'(lim) : ipart;
    idx_d = IW'(isel);
    frac_d = FW'(quo_q[NS-1] - {isel, {FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        bits_q[k] <= bits_d[k];
        div_q[k] <= div_in[k];
      end
      size_q[0] <= size_i;
      for (int k = 1; k < NS; k++) begin
        size_q[k] <= size_q[k-1];
      end
      idx_q <= idx_d;
      frac_q <= frac_d;
    end
  end

  assign idx_o = idx_q;
  assign frac_o = frac_q;

endmodule
